FILE: hdl/mcstg_pkg.sv
// Package for the multi-channel step tone generator.
// Holds the command codes, field widths and the per-channel control struct.
// No dependencies.
package mcstg_pkg;

   localparam int OP_BITS     = 3;
   localparam int DRIVER_BITS = 2;
   localparam int NOTE_BITS   = 7;
   localparam int REQ_PERIOD_BITS = 16;
   localparam int SWITCH_BITS = 3;
   localparam int LEVEL_BITS  = 3;

   localparam logic [NOTE_BITS-1:0] MAX_NOTE = 7'd119;
   localparam logic LVL_LOW  = 1'b0;
   localparam logic LVL_HIGH = 1'b1;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK     = 3'd0,
      OP_NOTE_ON  = 3'd1,
      OP_NOTE_OFF = 3'd2,
      OP_RESET    = 3'd3,
      OP_HALT     = 3'd4
   } op_type;

   // Decoded action for one channel.
   typedef struct packed {
      logic tick;
      logic load;
      logic stop;
      logic clear;
   } chan_cmd_type;

endpackage

FILE: hdl/mcstg_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on mcstg_pkg.
interface mcstg_req_if import mcstg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OP_BITS-1:0]         op;
   logic [DRIVER_BITS-1:0]     driver;
   logic [NOTE_BITS-1:0]       note;
   logic [REQ_PERIOD_BITS-1:0] period;
   logic [SWITCH_BITS-1:0]     front_pressed;
   logic [SWITCH_BITS-1:0]     rear_pressed;

   modport source (output valid, op, driver, note, period, front_pressed, rear_pressed,
                   input ready);
   modport sink (input valid, op, driver, note, period, front_pressed, rear_pressed,
                 output ready);
endinterface

interface mcstg_rsp_if import mcstg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] step_levels;
   logic [LEVEL_BITS-1:0] dir_levels;

   modport source (output valid, step_levels, dir_levels, input ready);
   modport sink (input valid, step_levels, dir_levels, output ready);
endinterface

FILE: hdl/multi_channel_step_tone_generator_top.sv
// Multi-channel step tone generator, top level. Accepts one request word per cycle
// when not stalled; the response word with the updated step and direction levels
// passes through the input register and then the channel state, which is also the
// response register. Every request word, whatever its op, gives exactly
// one response word. Back pressure on the response side stalls the input register
// and then the request side; with the response taken every cycle, one word per cycle.
// Depends on mcstg_pkg, mcstg_if, mcstg_dec and mcstg_chan.
module multi_channel_step_tone_generator_top import mcstg_pkg::*; #(
   parameter int NUM_CHANNELS = 3,
   parameter int PERIOD_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   mcstg_req_if.sink    req_chan,
   mcstg_rsp_if.source  rsp_chan
);

   logic                       s1_valid_ff, s1_valid_in;
   logic [OP_BITS-1:0]         s1_op_ff;
   logic [DRIVER_BITS-1:0]     s1_driver_ff;
   logic [NOTE_BITS-1:0]       s1_note_ff;
   logic [REQ_PERIOD_BITS-1:0] s1_period_ff;
   logic [SWITCH_BITS-1:0]     s1_front_ff;
   logic [SWITCH_BITS-1:0]     s1_rear_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       fire;
   logic                       req_take;
   logic [PERIOD_BITS-1:0]     period_val;
   chan_cmd_type               cmd [NUM_CHANNELS];
   logic                       step_lvl [NUM_CHANNELS];
   logic                       dir_lvl [NUM_CHANNELS];

   // The channel state advances only when the response slot is free or being emptied.
   assign fire     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || fire;

   assign s1_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff     <= req_chan.op;
         s1_driver_ff <= req_chan.driver;
         s1_note_ff   <= req_chan.note;
         s1_period_ff <= req_chan.period;
         s1_front_ff  <= req_chan.front_pressed;
         s1_rear_ff   <= req_chan.rear_pressed;
      end
   end

   assign period_val = PERIOD_BITS'(s1_period_ff);

   mcstg_dec #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_dec (
      .op     (s1_op_ff),
      .driver (s1_driver_ff),
      .note   (s1_note_ff),
      .cmd    (cmd)
   );

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      logic front_bit;
      logic rear_bit;

      // Limit switches exist only for the first three channels.
      if (c < SWITCH_BITS) begin : g_sw
         assign front_bit = s1_front_ff[c];
         assign rear_bit  = s1_rear_ff[c];
      end else begin : g_nosw
         assign front_bit = 1'b0;
         assign rear_bit  = 1'b0;
      end

      mcstg_chan #(
         .PERIOD_BITS(PERIOD_BITS)
      ) u_chan (
         .clock      (clock),
         .reset      (reset),
         .en         (fire),
         .cmd        (cmd[c]),
         .period_val (period_val),
         .front      (front_bit),
         .rear       (rear_bit),
         .step_level (step_lvl[c]),
         .dir_level  (dir_lvl[c])
      );
   end

   for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_out
      if (k < NUM_CHANNELS) begin : g_used
         assign rsp_chan.step_levels[k] = step_lvl[k];
         assign rsp_chan.dir_levels[k]  = dir_lvl[k];
      end else begin : g_unused
         assign rsp_chan.step_levels[k] = LVL_LOW;
         assign rsp_chan.dir_levels[k]  = LVL_LOW;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("state update without a response word");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !(s1_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("request taken while the pipeline is full");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !fire |=> s1_valid_ff && $stable(s1_op_ff) && $stable(s1_driver_ff))
      else $error("stalled input register lost its word");
`endif

endmodule

FILE: hdl/mcstg_dec.sv
// Command decoder: turns one registered request word into per-channel actions.
// Depends on mcstg_pkg.
module mcstg_dec import mcstg_pkg::*; #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic [OP_BITS-1:0]     op,
   input  logic [DRIVER_BITS-1:0] driver,
   input  logic [NOTE_BITS-1:0]   note,
   output chan_cmd_type           cmd [NUM_CHANNELS]
);

   op_type op_dec;
   logic   hit [NUM_CHANNELS];

   assign op_dec = op_type'(op);

   // Only channels one to three can be addressed by the two-bit driver field.
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      if (c < 3) begin : g_addr
         assign hit[c] = (driver == DRIVER_BITS'(c + 1));
      end else begin : g_noaddr
         assign hit[c] = 1'b0;
      end

      always_comb begin
         cmd[c] = '0;
         unique case (op_dec)
            OP_TICK:     cmd[c].tick = 1'b1;
            OP_NOTE_ON:  cmd[c].load = hit[c] && (note <= MAX_NOTE);
            OP_NOTE_OFF: cmd[c].stop = hit[c];
            OP_RESET:    cmd[c].clear = hit[c] || (driver == '0);
            OP_HALT:     cmd[c].stop = 1'b1;
            default:     cmd[c] = '0;
         endcase
      end
   end

endmodule

FILE: hdl/mcstg_chan.sv
// One tone channel: period, tick counter, step phase and pin levels.
// Depends on mcstg_pkg.
module mcstg_chan import mcstg_pkg::*; #(
   parameter int PERIOD_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  chan_cmd_type           cmd,
   input  logic [PERIOD_BITS-1:0] period_val,
   input  logic                   front,
   input  logic                   rear,
   output logic                   step_level,
   output logic                   dir_level
);

   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [PERIOD_BITS-1:0] count_ff, count_in;
   logic                   phase_ff, phase_in;
   logic                   step_ff, step_in;
   logic                   dir_ff, dir_in;
   logic [PERIOD_BITS-1:0] count_inc;

   assign count_inc = count_ff + PERIOD_BITS'(1);

   always_comb begin
      period_in = period_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      dir_in    = dir_ff;
      if (en) begin
         if (cmd.tick && (period_ff != '0)) begin
            if (count_inc >= period_ff) begin
               count_in = '0;
               if (front) begin
                  dir_in = LVL_HIGH;
               end else if (rear) begin
                  dir_in = LVL_LOW;
               end
               step_in  = phase_ff;
               phase_in = ~phase_ff;
            end else begin
               count_in = count_inc;
            end
         end
         if (cmd.load) begin
            period_in = period_val;
         end
         if (cmd.stop) begin
            period_in = '0;
         end
         // Clearing a channel leaves its counter alone.
         if (cmd.clear) begin
            period_in = '0;
            phase_in  = LVL_LOW;
            step_in   = LVL_LOW;
            dir_in    = LVL_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= LVL_LOW;
         step_ff   <= LVL_LOW;
         dir_ff    <= LVL_LOW;
      end else begin
         period_ff <= period_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         dir_ff    <= dir_in;
      end
   end

   assign step_level = step_ff;
   assign dir_level  = dir_ff;

`ifndef SYNTHESIS
   a_count_below_period: assert property (@(posedge clock) disable iff (reset)
      en && cmd.tick && !cmd.load && !cmd.stop && !cmd.clear && (period_ff != '0)
      |=> count_ff < period_ff)
      else $error("counter not below period after tick");

   a_idle_levels_hold: assert property (@(posedge clock) disable iff (reset)
      en && (period_ff == '0) && !cmd.clear |=> $stable(step_ff) && $stable(phase_ff))
      else $error("stopped channel changed its step level");

   a_clear_levels_low: assert property (@(posedge clock) disable iff (reset)
      en && cmd.clear |=> (period_ff == '0) && !step_ff && !phase_ff && !dir_ff)
      else $error("cleared channel kept a level or its period");
`endif

endmodule

FILE: sim/tb_multi_channel_step_tone_generator_top.sv
// Testbench for multi_channel_step_tone_generator_top: directed and random command words,
// checked against a cycle-free model of the three tone channels kept in this file.
// Depends on mcstg_pkg, mcstg_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_multi_channel_step_tone_generator_top;
   import mcstg_pkg::*;

   localparam int NUM_CHANNELS = 3;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_WORDS = 500;
   localparam int HOLD_CYCLES  = 80;
   localparam int TAIL_CYCLES  = 8;

   localparam logic [DRIVER_BITS-1:0] ALL_DRIVERS   = 2'd0;
   localparam logic [OP_BITS-1:0]     OP_UNUSED_LO  = 3'd5;
   localparam logic [OP_BITS-1:0]     OP_UNUSED_HI  = 3'd7;
   localparam logic [NOTE_BITS-1:0]   NOTE_TOP      = 7'd127;

   typedef struct packed {
      logic [OP_BITS-1:0]         op;
      logic [DRIVER_BITS-1:0]     driver;
      logic [NOTE_BITS-1:0]       note;
      logic [REQ_PERIOD_BITS-1:0] period;
      logic [SWITCH_BITS-1:0]     front;
      logic [SWITCH_BITS-1:0]     rear;
   } tone_cmd_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] step;
      logic [LEVEL_BITS-1:0] dir;
   } pin_levels_type;

   logic clock;
   logic reset;

   mcstg_req_if req_if ();
   mcstg_rsp_if rsp_if ();

   multi_channel_step_tone_generator_top #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .PERIOD_BITS (REQ_PERIOD_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   // Channel model state.
   logic [REQ_PERIOD_BITS-1:0] half_period [NUM_CHANNELS];
   logic [REQ_PERIOD_BITS-1:0] tick_count [NUM_CHANNELS];
   logic                       phase_bit [NUM_CHANNELS];
   logic                       step_bit [NUM_CHANNELS];
   logic                       dir_bit [NUM_CHANNELS];

   pin_levels_type expected_levels_q[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int hold_cycles_left;
   int cycle_count;
   int error_count;
   int words_sent;
   int responses_checked;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_tone_channel(int c);
      half_period[c] = '0;
      phase_bit[c]   = LVL_LOW;
      step_bit[c]    = LVL_LOW;
      dir_bit[c]     = LVL_LOW;
   endfunction

   // Advances the channel model by one word and returns the pin levels it leaves.
   function automatic pin_levels_type apply_tone_cmd(tone_cmd_type w);
      pin_levels_type lv;
      logic           chan_ok;
      int             idx;
      chan_ok = (w.driver >= 1) && (w.driver <= NUM_CHANNELS);
      idx     = chan_ok ? int'(w.driver) - 1 : 0;
      case (w.op)
         OP_TICK: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (half_period[c] != '0) begin
                  tick_count[c] = tick_count[c] + 1'b1;
                  // A count left above a lowered period toggles at once.
                  if (tick_count[c] >= half_period[c]) begin
                     if (w.front[c])
                        dir_bit[c] = LVL_HIGH;
                     else if (w.rear[c])
                        dir_bit[c] = LVL_LOW;
                     step_bit[c]   = phase_bit[c];
                     phase_bit[c]  = ~phase_bit[c];
                     tick_count[c] = '0;
                  end
               end
            end
         end
         OP_NOTE_ON: begin
            if (chan_ok && w.note <= MAX_NOTE)
               half_period[idx] = w.period;
         end
         OP_NOTE_OFF: begin
            if (chan_ok)
               half_period[idx] = '0;
         end
         OP_RESET: begin
            // The tick counter survives a channel reset.
            if (w.driver == ALL_DRIVERS) begin
               for (int c = 0; c < NUM_CHANNELS; c++)
                  clear_tone_channel(c);
            end else if (chan_ok) begin
               clear_tone_channel(idx);
            end
         end
         OP_HALT: begin
            for (int c = 0; c < NUM_CHANNELS; c++)
               half_period[c] = '0;
         end
         default: ;
      endcase
      lv = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         lv.step[c] = step_bit[c];
         lv.dir[c]  = dir_bit[c];
      end
      return lv;
   endfunction

   function automatic tone_cmd_type tone_word(logic [OP_BITS-1:0] op,
                                              logic [DRIVER_BITS-1:0] drv,
                                              logic [NOTE_BITS-1:0] note,
                                              logic [REQ_PERIOD_BITS-1:0] per,
                                              logic [SWITCH_BITS-1:0] front,
                                              logic [SWITCH_BITS-1:0] rear);
      tone_cmd_type w;
      w.op     = op;
      w.driver = drv;
      w.note   = note;
      w.period = per;
      w.front  = front;
      w.rear   = rear;
      return w;
   endfunction

   // Mostly ticks and playable notes with short periods so that channels toggle often.
   function automatic tone_cmd_type random_tone_cmd();
      tone_cmd_type w;
      int           pick;
      int           pick_per;
      w.op     = OP_TICK;
      w.driver = DRIVER_BITS'($urandom_range(3, 0));
      w.note   = NOTE_BITS'($urandom_range(NOTE_TOP, 0));
      w.period = REQ_PERIOD_BITS'($urandom_range(16'hFFFF, 0));
      w.front  = SWITCH_BITS'($urandom_range(7, 0));
      w.rear   = SWITCH_BITS'($urandom_range(7, 0));
      pick     = int'($urandom_range(99, 0));
      if (pick < 55) begin
         w.op = OP_TICK;
      end else if (pick < 75) begin
         w.op = OP_NOTE_ON;
         if ($urandom_range(9, 0) != 0)
            w.note = NOTE_BITS'($urandom_range(MAX_NOTE, 0));
         pick_per = int'($urandom_range(9, 0));
         if (pick_per < 8)
            w.period = REQ_PERIOD_BITS'($urandom_range(12, 1));
         else if (pick_per == 8)
            w.period = '0;
      end else if (pick < 83) begin
         w.op = OP_NOTE_OFF;
      end else if (pick < 90) begin
         w.op = OP_RESET;
      end else if (pick < 95) begin
         w.op = OP_HALT;
      end else begin
         w.op = OP_BITS'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end
      return w;
   endfunction

   task automatic report_mismatch(string what, int exp_val, int got_val);
      $display("[%0t] MISMATCH %s: expected %03b, got %03b", $realtime, what, exp_val,
               got_val);
      error_count++;
   endtask

   // Offers one word, with a random gap before it, and records the expected levels.
   task automatic send_word(input tone_cmd_type w);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.op            <= w.op;
      req_if.driver        <= w.driver;
      req_if.note          <= w.note;
      req_if.period        <= w.period;
      req_if.front_pressed <= w.front;
      req_if.rear_pressed  <= w.rear;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      expected_levels_q.push_back(apply_tone_cmd(w));
      words_sent++;
   endtask

   task automatic wait_for_responses();
      req_if.valid <= 1'b0;
      while (expected_levels_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_notes_and_ticks();
      send_word(tone_word(OP_TICK, 2'd1, '0, '0, 3'b111, 3'b111));
      send_word(tone_word(OP_NOTE_ON, 2'd1, '0, 16'd1, '0, '0));
      send_word(tone_word(OP_NOTE_ON, 2'd2, MAX_NOTE, 16'd2, '0, '0));
      send_word(tone_word(OP_NOTE_ON, 2'd3, MAX_NOTE + 1'b1, 16'd3, '0, '0));
      send_word(tone_word(OP_NOTE_ON, ALL_DRIVERS, 7'd60, 16'd1, '0, '0));
      send_word(tone_word(OP_TICK, 2'd0, NOTE_TOP, '1, 3'b001, 3'b110));
      send_word(tone_word(OP_TICK, 2'd3, '0, '0, 3'b000, 3'b111));
      send_word(tone_word(OP_TICK, 2'd0, '0, '0, 3'b111, 3'b000));
      send_word(tone_word(OP_NOTE_ON, 2'd3, NOTE_TOP, '1, '0, '0));
      send_word(tone_word(OP_NOTE_ON, 2'd3, 7'd100, '1, '0, '0));
      send_word(tone_word(OP_TICK, 2'd1, '0, '0, 3'b010, 3'b101));
   endtask

   task automatic test_stale_counter();
      send_word(tone_word(OP_NOTE_ON, 2'd2, 7'd64, 16'd6, '0, '0));
      repeat (3)
         send_word(tone_word(OP_TICK, 2'd0, '0, '0, 3'b000, 3'b010));
      send_word(tone_word(OP_NOTE_ON, 2'd2, 7'd64, 16'd2, '0, '0));
      send_word(tone_word(OP_TICK, 2'd0, '0, '0, 3'b010, 3'b000));
   endtask

   task automatic test_reset_and_halt();
      send_word(tone_word(OP_RESET, 2'd2, '0, '0, '0, '0));
      send_word(tone_word(OP_NOTE_ON, 2'd2, 7'd10, 16'd3, '0, '0));
      send_word(tone_word(OP_TICK, 2'd0, '0, '0, 3'b111, 3'b000));
      send_word(tone_word(OP_NOTE_OFF, ALL_DRIVERS, '0, '0, '0, '0));
      send_word(tone_word(OP_NOTE_OFF, 2'd1, '0, '0, '0, '0));
      send_word(tone_word(OP_HALT, 2'd3, '0, '0, '0, '0));
      send_word(tone_word(OP_RESET, ALL_DRIVERS, '0, '0, '0, '0));
   endtask

   task automatic test_unused_ops();
      for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
         send_word(tone_word(u[OP_BITS-1:0], 2'd1, 7'd5, 16'd1, 3'b111, 3'b111));
   endtask

   // The response side holds off while words keep coming, so the block fills and
   // stalls its input; then the sender waits until everything has drained.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_word(tone_word(OP_NOTE_ON, 2'd1, 7'd30, 16'd1, '0, '0));
      hold_cycles_left <= HOLD_CYCLES;
      repeat (24)
         send_word(random_tone_cmd());
      wait_for_responses();
   endtask

   task automatic test_random_traffic(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (RANDOM_WORDS)
         send_word(random_tone_cmd());
      wait_for_responses();
   endtask

   initial begin : rsp_hold_counter
      forever begin
         @(posedge clock);
         if (hold_cycles_left > 0)
            hold_cycles_left <= hold_cycles_left - 1;
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= (hold_cycles_left == 0) && ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : level_checker
      pin_levels_type exp_lv;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_levels_q.size() == 0) begin
            $display("[%0t] MISMATCH response word with nothing expected", $realtime);
            error_count++;
         end else begin
            exp_lv = expected_levels_q.pop_front();
            if (rsp_if.step_levels !== exp_lv.step)
               report_mismatch("step_levels", int'(exp_lv.step), int'(rsp_if.step_levels));
            if (rsp_if.dir_levels !== exp_lv.dir)
               report_mismatch("dir_levels", int'(exp_lv.dir), int'(rsp_if.dir_levels));
            responses_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("multi_channel_step_tone_generator_top test failed");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.op            = OP_TICK;
      req_if.driver        = '0;
      req_if.note          = '0;
      req_if.period        = '0;
      req_if.front_pressed = '0;
      req_if.rear_pressed  = '0;
      rsp_if.ready         = 1'b0;
      send_idle_pct        = 0;
      rsp_stall_pct        = 0;
      hold_cycles_left     = 0;
      cycle_count          = 0;
      error_count          = 0;
      words_sent           = 0;
      responses_checked    = 0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         clear_tone_channel(c);
         tick_count[c] = '0;
      end
      repeat (4)
         @(posedge clock);
      reset <= 1'b0;

      test_notes_and_ticks();
      test_stale_counter();
      test_reset_and_halt();
      test_unused_ops();
      wait_for_responses();
      test_backpressure();
      test_random_traffic(0, 0);
      test_random_traffic(73, 0);
      test_random_traffic(0, 73);
      test_random_traffic(12, 12);

      wait_for_responses();
      repeat (TAIL_CYCLES)
         @(posedge clock);
      $display("Sent %0d command words and checked %0d response words, %0d mismatches.",
               words_sent, responses_checked, error_count);
      $display("Covered every op, unused codes, stale counters, resets and back pressure.");
      if (error_count == 0)
         $display("multi_channel_step_tone_generator_top test passed");
      else
         $display("multi_channel_step_tone_generator_top test failed");
      $finish;
   end

endmodule
